// File: rtl/penalized_coordinate_threshold_defines.svh
// Assertion macros shared by the penalized coordinate threshold RTL.
`ifndef PENALIZED_COORDINATE_THRESHOLD_DEFINES_SVH
`define PENALIZED_COORDINATE_THRESHOLD_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PCT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled in reset
`define PCT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: rtl/pct_pkg.sv
// Package: codes, types and constants of the penalized coordinate threshold.
`timescale 1ns / 1ps
`default_nettype none
package pct_pkg;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DIV_STEPS   = VALUE_WIDTH + FRAC_BITS;

    localparam logic [1:0] MODE_SOFT = 2'd0;
    localparam logic [1:0] MODE_MCP  = 2'd1;
    localparam logic [1:0] MODE_SCAD = 2'd2;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_LAMBDA = 2'd1;
    localparam logic [1:0] REG_GAMMA  = 2'd2;
    localparam logic [1:0] REG_ALPHA  = 2'd3;

    typedef enum logic [2:0] {C_LAM, C_PROD, C_BAND, C_DIV, C_DONE} t_cfg_state;
    typedef enum logic [1:0] {OP_RECIP_M, OP_RECIP_S, OP_THR} t_div_op;

    typedef struct packed {
        logic        busy;
        logic [1:0]  mode;
        logic [30:0] lambda;
        logic [30:0] lam1;
        logic [31:0] one_lam2;
        logic [31:0] fac_m;
        logic [31:0] fac_s;
        logic [32:0] band_m;
        logic [32:0] band_1;
        logic [32:0] band_s;
        logic [32:0] thr;
    } t_derived;

    typedef struct packed {
        logic [46:0] rem;
        logic [47:0] dvd;
        logic [47:0] quo;
        logic [46:0] den;
        logic        neg;
        logic        zero;
        logic        byp;
        logic [31:0] bmag;
    } t_div_beat;
endpackage
`default_nettype wire

// File: rtl/penalized_coordinate_threshold.sv
// Top level: penalty selection, divisor product, division cell row, saturation.
//
//   channel  | direction | payload
//   s (in)   | slave     | tdata: zeta_value[31:0], nu_scale[62:32], zero pad [63]
//   m (out)  | master    | tdata: coefficient[31:0]; tuser: saturated
//   cfg      | write     | idx selects mode, lambda, gamma, alpha; wdata 31 bits
//
// One beat per cycle unless the output stalls or the sequencer is busy. Stages:
// select, product, 48 division cells, output register. After reset and config
// writes the sequencer runs lambda, product and band steps, then 3 divisions of
// 64 steps; s_tready stays low meanwhile. A stalled output holds the whole row.
`timescale 1ns / 1ps
`default_nettype none
`include "penalized_coordinate_threshold_defines.svh"
module penalized_coordinate_threshold (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // zeta_value, nu_scale, pad
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // coefficient
    output logic             o_m_tuser,   // saturated
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [30:0] i_cfg_wdata
);
    localparam int N = pct_pkg::DIV_STEPS;

    pct_pkg::t_derived  w_d;
    pct_pkg::t_div_beat w_beat [0:N];
    pct_pkg::t_div_beat r_beat0;
    logic               w_cv   [0:N];

    logic        w_adv, w_acc;
    logic [31:0] w_raw, w_az, w_n, w_fac, w_bmag;
    logic        w_neg, w_zero, w_byp;
    logic [32:0] w_az33;

    logic        r1_v, r1_neg, r1_zero, r1_byp;
    logic [31:0] r1_n, r1_fac, r1_bmag;
    logic [30:0] r1_nu;
    logic        r2_v;
    logic [62:0] w_prod;

    logic [47:0] w_mag, w_lim;
    logic        w_sat;
    logic [31:0] w_magc;
    logic        r_ov, r_sat;
    logic [31:0] r_coef;

    pct_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_derived  (w_d)
    );

    assign w_adv      = !r_ov || i_m_tready;
    assign o_s_tready = w_adv && !w_d.busy;
    assign w_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        w_raw  = i_s_tdata[31:0];
        w_neg  = w_raw[31];
        w_az   = w_neg ? 32'(~w_raw + 32'd1) : w_raw;
        w_az33 = {1'b0, w_az};
        w_n    = w_az;
        w_fac  = w_d.one_lam2;
        w_zero = 1'b0;
        w_byp  = 1'b0;
        w_bmag = (w_az > {1'b0, w_d.lambda}) ? 32'(w_az - {1'b0, w_d.lambda}) : 32'd0;
        case (w_d.mode)
            pct_pkg::MODE_MCP: begin
                if (w_az <= {1'b0, w_d.lam1}) begin
                    w_zero = 1'b1;
                end else if (w_az33 <= w_d.band_m) begin
                    w_n   = 32'(w_az - {1'b0, w_d.lam1});
                    w_fac = w_d.fac_m;
                end
            end
            pct_pkg::MODE_SCAD: begin
                if (w_az <= {1'b0, w_d.lam1}) begin
                    w_zero = 1'b1;
                end else if (w_az33 <= w_d.band_1) begin
                    w_n = 32'(w_az - {1'b0, w_d.lam1});
                end else if (w_az33 <= w_d.band_s) begin
                    if (w_az33 <= w_d.thr) begin
                        w_zero = 1'b1;
                    end else begin
                        w_n   = 32'(w_az - w_d.thr[31:0]);
                        w_fac = w_d.fac_s;
                    end
                end
            end
            default: w_byp = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r1_v <= w_acc;
            r2_v <= r1_v;
            r_ov <= w_cv[N];
        end
    end

    assign w_prod = {32'b0, r1_nu} * {31'b0, r1_fac};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_n    <= w_n;
            r1_fac  <= w_fac;
            r1_nu   <= i_s_tdata[62:32];
            r1_neg  <= w_neg;
            r1_zero <= w_zero;
            r1_byp  <= w_byp;
            r1_bmag <= w_bmag;
            r_beat0.rem  <= 47'd0;
            r_beat0.dvd  <= {r1_n, 16'b0};
            r_beat0.quo  <= 48'd0;
            r_beat0.den  <= w_prod[62:16];
            r_beat0.neg  <= r1_neg;
            r_beat0.zero <= r1_zero || (r1_n == 32'd0);
            r_beat0.byp  <= r1_byp;
            r_beat0.bmag <= r1_bmag;
        end
    end
    assign w_beat[0] = r_beat0;
    assign w_cv[0]   = r2_v;

    for (genvar g = 0; g < N; g++) begin : g_cell
        pct_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_adv),
            .i_valid(w_cv[g]),
            .i_beat (w_beat[g]),
            .o_valid(w_cv[g+1]),
            .o_beat (w_beat[g+1])
        );
    end

    always_comb begin
        w_mag = w_beat[N].zero ? 48'd0
              : (w_beat[N].byp ? {16'b0, w_beat[N].bmag} : w_beat[N].quo);
        w_lim = w_beat[N].neg ? 48'h8000_0000 : 48'h7FFF_FFFF;
        w_sat = (w_mag > w_lim);
        w_magc = w_sat ? w_lim[31:0] : w_mag[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_coef <= w_beat[N].neg ? 32'(~w_magc + 32'd1) : w_magc;
            r_sat  <= w_sat;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_coef;
    assign o_m_tuser  = r_sat;

    `PCT_ASSERT_IMP(a_sat_extreme, r_ov && r_sat,
                    r_coef == 32'h7FFF_FFFF || r_coef == 32'h8000_0000)
    `PCT_ASSERT_IMP(a_zero_unsat, r_ov && r_coef == 32'd0, !r_sat)
    `PCT_ASSERT_NXT(a_cfg_blocks, i_cfg_we, !o_s_tready)
endmodule
`default_nettype wire

// File: rtl/pct_div_cell.sv
// One restoring-division cell: settles one quotient bit and hands on the beat.
`timescale 1ns / 1ps
`default_nettype none
module pct_div_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire pct_pkg::t_div_beat i_beat,
    output logic                   o_valid,
    output pct_pkg::t_div_beat     o_beat
);
    logic               r_valid;
    pct_pkg::t_div_beat r_beat;
    pct_pkg::t_div_beat n_beat;
    logic [47:0]        w_sh;
    logic               w_ge;

    always_comb begin
        w_sh   = {i_beat.rem, i_beat.dvd[47]};
        w_ge   = (w_sh >= {1'b0, i_beat.den});
        n_beat = i_beat;
        n_beat.rem = w_ge ? 47'(w_sh - {1'b0, i_beat.den}) : w_sh[46:0];
        n_beat.dvd = {i_beat.dvd[46:0], 1'b0};
        n_beat.quo = {i_beat.quo[46:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;
endmodule
`default_nettype wire

// File: rtl/pct_cfg.sv
// Configuration registers and sequencer that derives the penalty constants.
`timescale 1ns / 1ps
`default_nettype none
module pct_cfg (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [30:0]  i_cfg_wdata,
    output pct_pkg::t_derived o_derived
);
    pct_pkg::t_cfg_state r_state, n_state;
    pct_pkg::t_div_op    r_op;
    logic [1:0]  r_mode;
    logic [30:0] r_lambda, r_gamma;
    logic [16:0] r_alpha;
    logic [30:0] r_lam1, r_lam2, r_gm, r_gs;
    logic [32:0] r_pmc, r_band1, r_bandm, r_bands, r_thr;
    logic [45:0] r_ps;
    logic [15:0] r_rm, r_rs;
    logic [63:0] r_dvd, r_quo;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;

    logic [16:0] w_alpha;
    logic [47:0] w_lam_prod;
    logic [61:0] w_pm_prod, w_ps_prod;
    logic [62:0] w_b1_prod;
    logic [64:0] w_bm_prod, w_bs_prod;
    logic [31:0] w_one_lam2;
    logic [32:0] w_psc;
    logic [30:0] w_gs1;
    logic [31:0] w_den;
    logic [32:0] w_sh;
    logic        w_ge;
    logic [63:0] w_quo;
    logic        w_busy;

    always_comb begin
        w_alpha    = (r_alpha > 17'h10000) ? 17'h10000 : r_alpha;
        w_lam_prod = {17'b0, r_lambda} * {31'b0, w_alpha};
        w_pm_prod  = {31'b0, r_gm} * {31'b0, r_lam1};
        w_ps_prod  = {31'b0, r_gs} * {31'b0, r_lam1};
        w_b1_prod  = {32'b0, r_lam1} * (63'h20000 + {32'b0, r_lam2});
        w_one_lam2 = 32'h10000 + {1'b0, r_lam2};
        w_psc      = (r_ps > 46'h1_0000_0000) ? 33'h1_0000_0000 : r_ps[32:0];
        w_bm_prod  = {32'b0, r_pmc} * {33'b0, w_one_lam2};
        w_bs_prod  = {32'b0, w_psc} * {33'b0, w_one_lam2};
        w_gs1      = r_gs - 31'h10000;
        w_den      = (r_op == pct_pkg::OP_RECIP_M) ? {1'b0, r_gm} : {1'b0, w_gs1};
        w_sh       = {r_rem, r_dvd[63]};
        w_ge       = (w_sh >= {1'b0, w_den});
        w_quo      = {r_quo[62:0], w_ge};
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pct_pkg::C_LAM:  n_state = pct_pkg::C_PROD;
            pct_pkg::C_PROD: n_state = pct_pkg::C_BAND;
            pct_pkg::C_BAND: n_state = pct_pkg::C_DIV;
            pct_pkg::C_DIV: begin
                if (r_cnt == 6'd0 && r_op == pct_pkg::OP_THR) n_state = pct_pkg::C_DONE;
            end
            pct_pkg::C_DONE: n_state = pct_pkg::C_DONE;
            default:         n_state = pct_pkg::C_LAM;
        endcase
        if (i_cfg_we) n_state = pct_pkg::C_LAM;
    end

    // outputs
    always_comb begin
        w_busy = 1'b1;
        unique case (r_state)
            pct_pkg::C_DONE: w_busy = 1'b0;
            default:         w_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pct_pkg::C_LAM;
            r_mode   <= pct_pkg::MODE_MCP;
            r_lambda <= 31'd65536;
            r_gamma  <= 31'd242483;
            r_alpha  <= 17'd65536;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pct_pkg::REG_MODE:   r_mode   <= i_cfg_wdata[1:0];
                    pct_pkg::REG_LAMBDA: r_lambda <= i_cfg_wdata;
                    pct_pkg::REG_GAMMA:  r_gamma  <= i_cfg_wdata;
                    pct_pkg::REG_ALPHA:  r_alpha  <= i_cfg_wdata[16:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            pct_pkg::C_LAM: begin
                r_lam1 <= w_lam_prod[46:16];
                r_lam2 <= r_lambda - w_lam_prod[46:16];
                r_gm   <= (r_gamma < 31'h10001) ? 31'h10001 : r_gamma;
                r_gs   <= (r_gamma < 31'h20001) ? 31'h20001 : r_gamma;
            end
            pct_pkg::C_PROD: begin
                r_pmc   <= (w_pm_prod[61:16] > 46'h1_0000_0000) ? 33'h1_0000_0000
                                                                 : w_pm_prod[48:16];
                r_ps    <= w_ps_prod[61:16];
                r_band1 <= (w_b1_prod[62:16] > 47'h1_0000_0000) ? 33'h1_0000_0000
                                                                 : w_b1_prod[48:16];
            end
            pct_pkg::C_BAND: begin
                r_bandm <= (w_bm_prod[64:16] > 49'h1_0000_0000) ? 33'h1_0000_0000
                                                                 : w_bm_prod[48:16];
                r_bands <= (w_bs_prod[64:16] > 49'h1_0000_0000) ? 33'h1_0000_0000
                                                                 : w_bs_prod[48:16];
                r_op  <= pct_pkg::OP_RECIP_M;
                r_dvd <= 64'h1_0000_0000;
                r_rem <= 32'd0;
                r_quo <= 64'd0;
                r_cnt <= 6'd63;
            end
            pct_pkg::C_DIV: begin
                if (r_cnt == 6'd0) begin
                    r_rem <= 32'd0;
                    r_quo <= 64'd0;
                    r_cnt <= 6'd63;
                    case (r_op)
                        pct_pkg::OP_RECIP_M: begin
                            r_rm  <= w_quo[15:0];
                            r_op  <= pct_pkg::OP_RECIP_S;
                            r_dvd <= 64'h1_0000_0000;
                        end
                        pct_pkg::OP_RECIP_S: begin
                            r_rs  <= w_quo[15:0];
                            r_op  <= pct_pkg::OP_THR;
                            r_dvd <= {2'b0, r_ps, 16'b0};
                        end
                        default: begin
                            r_thr <= (w_quo > 64'h1_0000_0000) ? 33'h1_0000_0000
                                                                : w_quo[32:0];
                        end
                    endcase
                end else begin
                    r_rem <= w_ge ? 32'(w_sh - {1'b0, w_den}) : w_sh[31:0];
                    r_dvd <= {r_dvd[62:0], 1'b0};
                    r_quo <= w_quo;
                    r_cnt <= r_cnt - 6'd1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_derived.busy     = w_busy;
        o_derived.mode     = r_mode;
        o_derived.lambda   = r_lambda;
        o_derived.lam1     = r_lam1;
        o_derived.one_lam2 = w_one_lam2;
        o_derived.fac_m    = 32'(w_one_lam2 - {16'b0, r_rm});
        o_derived.fac_s    = 32'(w_one_lam2 - {16'b0, r_rs});
        o_derived.band_m   = r_bandm;
        o_derived.band_1   = r_band1;
        o_derived.band_s   = r_bands;
        o_derived.thr      = r_thr;
    end
endmodule
`default_nettype wire
